// ----- design/clx_pkg.sv -----
// clx_pkg: shared types, character codes and small decode functions for the
// comment-stripping lexer. No dependencies; used by the interfaces and the top level.

package clx_pkg;

    typedef enum logic [4:0] {
        KIND_ELSE, KIND_IF, KIND_INT, KIND_RETURN, KIND_VOID, KIND_WHILE,
        KIND_PLUS, KIND_MINUS, KIND_STAR, KIND_SLASH, KIND_LT, KIND_LE,
        KIND_GT, KIND_GE, KIND_EQ, KIND_NE, KIND_ASSIGN, KIND_SEMI,
        KIND_COMMA, KIND_LPAREN, KIND_RPAREN, KIND_LBRACK, KIND_RBRACK,
        KIND_LBRACE, KIND_RBRACE, KIND_NUM, KIND_ID, KIND_EOF, KIND_BAD,
        KIND_OPEN
    } kind_t;

    typedef enum logic [1:0] {
        STRIP_NORMAL, STRIP_SLASH, STRIP_COMMENT, STRIP_STAR
    } strip_mode_t;

    typedef enum logic [1:0] {
        LEX_START, LEX_NUM, LEX_ID, LEX_REL
    } lex_mode_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam int KW_COUNT = 6;

    // keyword spellings, first character in the low byte
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_6573_6C65,
        48'h0000_0000_6669,
        48'h0000_0074_6E69,
        48'h6E72_7574_6572,
        48'h0000_6469_6F76,
        48'h0065_6C69_6877
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd4, 8'd2, 8'd3, 8'd6, 8'd4, 8'd5};

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  length;
        logic [63:0] text_head;
        logic [30:0] num_value;
    } tok_res_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [7:0]  length;
        logic [63:0] text_head;
        logic [30:0] num_value;
        logic        last_of_run;
    } out_item_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_rel(input logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_BANG) || (c == CH_EQ);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic hit;
        unique case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E, 8'h3D, 8'h3B,
            8'h2C, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic kind_t symbol_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h3D:   k = KIND_ASSIGN;
            8'h3B:   k = KIND_SEMI;
            8'h2C:   k = KIND_COMMA;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

    function automatic kind_t rel_pair_kind(input logic [7:0] head);
        kind_t k;
        priority if (head == CH_LT) k = KIND_LE;
        else if (head == CH_GT)     k = KIND_GE;
        else if (head == CH_EQ)     k = KIND_EQ;
        else                        k = KIND_NE;
        return k;
    endfunction

    // bytes above the token length are zero, so a full compare of the low six bytes works
    function automatic kind_t word_kind(input logic [47:0] text, input logic [7:0] len);
        kind_t k;
        k = KIND_ID;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if ((len == KW_LEN[i]) && (text == KW_TEXT[i]))
            begin
                k = kind_t'(5'(i));
            end
        end
        return k;
    endfunction

endpackage

// ----- design/clx_if.sv -----
// clx_if: valid/ready channel interfaces for source characters and tokens.
// Depends on clx_pkg for the token kind type.

interface clx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, ch, end_of_text, input ready);
    modport sink   (input valid, ch, end_of_text, output ready);
endinterface

interface clx_out_if;
    logic          valid;
    logic          ready;
    clx_pkg::kind_t kind;
    logic [15:0]   line;
    logic [7:0]    length;
    logic [63:0]   text_head;
    logic [30:0]   num_value;
    logic          last_of_run;

    modport source (output valid, kind, line, length, text_head, num_value, last_of_run,
                    input ready);
    modport sink   (input valid, kind, line, length, text_head, num_value, last_of_run,
                    output ready);
endinterface

// ----- design/comment_stripping_lexer.sv -----
// comment_stripping_lexer: strips block comments and tokenizes source characters.
// Depends on clx_pkg and the channel interfaces in clx_if.sv.
// Each accepted character is registered, then its tokens go to the registered result buffer.
// Throughput: one character per cycle while each gives at most one token and the token output
// is not stalled; a character giving k tokens (up to 3) holds the next token-giving character.
// Reset (async, active low): normal text, no token, line 1, not halted, buffer empty.

module comment_stripping_lexer #(
    parameter int HEAD_CHARS = 8,
    parameter int LINE_BITS  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    clx_in_if.sink          char_in,
    clx_out_if.source       token_out
);

    localparam int TW = 8 * HEAD_CHARS;

    typedef struct packed {
        clx_pkg::lex_mode_t mode;
        logic [TW-1:0]      text;
        logic [7:0]         len;
        logic [30:0]        num;
    } tok_t;

    typedef struct packed {
        tok_t                       tok;
        logic [LINE_BITS-1:0]       line;
        logic                       halt;
        logic [1:0]                 rv;
        clx_pkg::tok_res_t [1:0]    r;
    } lex_out_t;

    localparam tok_t TOK_CLEAN = '0;

    function automatic tok_t append(input tok_t t, input logic [7:0] c);
        tok_t o;
        o = t;
        if (t.len < 8'(HEAD_CHARS))
        begin
            o.text = t.text | (TW'(c) << {t.len, 3'b000});
        end
        if (t.len != 8'hFF)
        begin
            o.len = t.len + 8'd1;
        end
        return o;
    endfunction

    function automatic tok_t add_digit(input tok_t t, input logic [7:0] c);
        tok_t        o;
        logic [34:0] acc;
        o   = append(t, c);
        acc = {1'b0, t.num, 3'b000} + {3'b000, t.num, 1'b0} + 35'(c - clx_pkg::CH_DIGIT0);
        o.num = (acc > 35'(clx_pkg::NUM_MAX)) ? clx_pkg::NUM_MAX : acc[30:0];
        return o;
    endfunction

    function automatic clx_pkg::tok_res_t mk_res(input clx_pkg::kind_t k, input logic [7:0] len,
                                                 input logic [63:0] text,
                                                 input logic [30:0] num);
        clx_pkg::tok_res_t r;
        r.kind      = k;
        r.length    = len;
        r.text_head = text;
        r.num_value = num;
        return r;
    endfunction

    // one character through the tokenizer: a flush or pair result, then a start result
    function automatic lex_out_t lex_char(input tok_t t, input logic [LINE_BITS-1:0] ln,
                                          input logic [7:0] c);
        lex_out_t       o;
        tok_t           tmp;
        logic           done;
        logic [7:0]     head;
        o      = '0;
        o.tok  = t;
        o.line = ln;
        done   = 1'b0;
        head   = t.text[7:0];
        tmp    = t;
        unique case (t.mode)
            clx_pkg::LEX_NUM:
            begin
                if (clx_pkg::is_digit(c))
                begin
                    o.tok = add_digit(t, c);
                    done  = 1'b1;
                end
                else
                begin
                    o.rv[0] = 1'b1;
                    o.r[0]  = mk_res(clx_pkg::KIND_NUM, t.len, 64'(t.text), t.num);
                end
            end
            clx_pkg::LEX_ID:
            begin
                if (clx_pkg::is_letter(c))
                begin
                    o.tok = append(t, c);
                    done  = 1'b1;
                end
                else
                begin
                    o.rv[0] = 1'b1;
                    o.r[0]  = mk_res(clx_pkg::word_kind(t.text[47:0], t.len), t.len,
                                     64'(t.text), 31'd0);
                end
            end
            clx_pkg::LEX_REL:
            begin
                if (c == clx_pkg::CH_EQ)
                begin
                    tmp     = append(t, c);
                    o.rv[0] = 1'b1;
                    o.r[0]  = mk_res(clx_pkg::rel_pair_kind(head), tmp.len, 64'(tmp.text),
                                     31'd0);
                    o.tok   = TOK_CLEAN;
                    done    = 1'b1;
                end
                else if (!clx_pkg::is_symbol(head))
                begin
                    o.rv[0] = 1'b1;
                    o.r[0]  = mk_res(clx_pkg::KIND_BAD, 8'd1, 64'(head), 31'd0);
                    o.halt  = 1'b1;
                    o.tok   = TOK_CLEAN;
                    done    = 1'b1;
                end
                else
                begin
                    o.rv[0] = 1'b1;
                    o.r[0]  = mk_res(clx_pkg::symbol_kind(head), t.len, 64'(t.text), 31'd0);
                end
            end
            clx_pkg::LEX_START:
            begin
                done = 1'b0;
            end
        endcase
        if (!done)
        begin
            o.tok = TOK_CLEAN;
            priority if (clx_pkg::is_space(c))
            begin
                if ((c == clx_pkg::CH_NL) && (ln != '1))
                begin
                    o.line = ln + 1'b1;
                end
            end
            else if (clx_pkg::is_digit(c))
            begin
                o.tok.mode = clx_pkg::LEX_NUM;
                o.tok.text = TW'(c);
                o.tok.len  = 8'd1;
                o.tok.num  = 31'(8'(c - clx_pkg::CH_DIGIT0));
            end
            else if (clx_pkg::is_letter(c))
            begin
                o.tok.mode = clx_pkg::LEX_ID;
                o.tok.text = TW'(c);
                o.tok.len  = 8'd1;
            end
            else if (clx_pkg::is_rel(c))
            begin
                o.tok.mode = clx_pkg::LEX_REL;
                o.tok.text = TW'(c);
                o.tok.len  = 8'd1;
            end
            else if (clx_pkg::is_symbol(c))
            begin
                o.rv[1] = 1'b1;
                o.r[1]  = mk_res(clx_pkg::symbol_kind(c), 8'd1, 64'(c), 31'd0);
            end
            else
            begin
                o.rv[1] = 1'b1;
                o.r[1]  = mk_res(clx_pkg::KIND_BAD, 8'd1, 64'(c), 31'd0);
                o.halt  = 1'b1;
            end
        end
        return o;
    endfunction

    // input register
    logic                   in_v_reg;
    logic [7:0]             ch_reg;
    logic                   eot_reg;

    // lexer state
    clx_pkg::strip_mode_t   strip_reg, strip_next;
    tok_t                   tok_reg, tok_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   halted_reg, halted_next;

    // result buffer
    clx_pkg::out_item_t     res_reg [4];
    logic [2:0]             cnt_reg;

    clx_pkg::tok_res_t [3:0] cand;
    logic [3:0]             cand_v;
    clx_pkg::out_item_t     new_res [4];
    logic [2:0]             n_new;
    logic [15:0]            line16;
    logic [31:0]            line_w;
    logic                   eot;
    logic                   buf_free;
    logic                   process;
    logic                   pop;
    lex_out_t               lx_c, lx_sl, lx_sp, lx_cl;

    assign eot      = eot_reg || (ch_reg == clx_pkg::CH_NUL);
    assign line_w   = 32'(line_reg);
    assign line16   = (line_w > 32'h0000_FFFF) ? 16'hFFFF : line_w[15:0];
    assign pop      = token_out.valid && token_out.ready;
    assign buf_free = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && token_out.ready);
    assign process  = in_v_reg && ((n_new == 3'd0) || buf_free);

    assign lx_c  = lex_char(tok_reg, line_reg, ch_reg);
    assign lx_sl = lex_char(tok_reg, line_reg, clx_pkg::CH_SLASH);
    assign lx_sp = lex_char(tok_reg, line_reg, clx_pkg::CH_SPACE);
    assign lx_cl = lex_char(TOK_CLEAN, line_reg, ch_reg);

    // next state
    always_comb
    begin
        strip_next  = strip_reg;
        tok_next    = tok_reg;
        line_next   = line_reg;
        halted_next = halted_reg;
        cand        = '0;
        cand_v      = '0;
        if (!halted_reg)
        begin
            if (eot)
            begin
                if ((strip_reg == clx_pkg::STRIP_COMMENT) || (strip_reg == clx_pkg::STRIP_STAR))
                begin
                    cand_v[0]   = 1'b1;
                    cand[0]     = mk_res(clx_pkg::KIND_OPEN, 8'd0, 64'd0, 31'd0);
                    halted_next = 1'b1;
                end
                else
                begin
                    cand_v[0] = lx_sp.rv[0];
                    cand[0]   = lx_sp.r[0];
                    tok_next  = TOK_CLEAN;
                    if (lx_sp.halt)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        cand_v[1]  = 1'b1;
                        cand[1]    = mk_res(clx_pkg::KIND_EOF, 8'd0, 64'd0, 31'd0);
                        strip_next = clx_pkg::STRIP_NORMAL;
                        line_next  = LINE_BITS'(1);
                    end
                end
            end
            else
            begin
                unique case (strip_reg)
                    clx_pkg::STRIP_NORMAL:
                    begin
                        if (ch_reg == clx_pkg::CH_SLASH)
                        begin
                            strip_next = clx_pkg::STRIP_SLASH;
                        end
                        else
                        begin
                            tok_next    = lx_c.tok;
                            line_next   = lx_c.line;
                            halted_next = lx_c.halt;
                            cand_v[1:0] = lx_c.rv;
                            cand[1:0]   = lx_c.r;
                        end
                    end
                    clx_pkg::STRIP_SLASH:
                    begin
                        if (ch_reg == clx_pkg::CH_STAR)
                        begin
                            strip_next = clx_pkg::STRIP_COMMENT;
                        end
                        else
                        begin
                            strip_next  = clx_pkg::STRIP_NORMAL;
                            tok_next    = lx_sl.tok;
                            halted_next = lx_sl.halt;
                            cand_v[1:0] = lx_sl.rv;
                            cand[1:0]   = lx_sl.r;
                            // held slash leaves a clean token, so the follower starts fresh
                            if (!lx_sl.halt)
                            begin
                                tok_next    = lx_cl.tok;
                                line_next   = lx_cl.line;
                                halted_next = lx_cl.halt;
                                cand_v[3:2] = lx_cl.rv;
                                cand[3:2]   = lx_cl.r;
                            end
                        end
                    end
                    clx_pkg::STRIP_COMMENT:
                    begin
                        if (ch_reg == clx_pkg::CH_STAR)
                        begin
                            strip_next = clx_pkg::STRIP_STAR;
                        end
                    end
                    clx_pkg::STRIP_STAR:
                    begin
                        if (ch_reg == clx_pkg::CH_SLASH)
                        begin
                            strip_next = clx_pkg::STRIP_NORMAL;
                        end
                        else if (ch_reg != clx_pkg::CH_STAR)
                        begin
                            strip_next = clx_pkg::STRIP_COMMENT;
                        end
                    end
                endcase
            end
        end
    end

    // pack the valid results in order and mark the last one
    always_comb
    begin
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            new_res[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i])
            begin
                new_res[pos[1:0]].kind      = cand[i].kind;
                new_res[pos[1:0]].line      = line16;
                new_res[pos[1:0]].length    = cand[i].length;
                new_res[pos[1:0]].text_head = cand[i].text_head;
                new_res[pos[1:0]].num_value = cand[i].num_value;
                pos = pos + 3'd1;
            end
        end
        n_new = pos;
        for (int i = 0; i < 4; i++)
        begin
            new_res[i].last_of_run = (3'(i) == (pos - 3'd1)) && (pos != 3'd0);
        end
    end

    // outputs
    always_comb
    begin
        char_in.ready         = !in_v_reg || process;
        token_out.valid       = (cnt_reg != 3'd0);
        token_out.kind        = res_reg[0].kind;
        token_out.line        = res_reg[0].line;
        token_out.length      = res_reg[0].length;
        token_out.text_head   = res_reg[0].text_head;
        token_out.num_value   = res_reg[0].num_value;
        token_out.last_of_run = res_reg[0].last_of_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            strip_reg  <= clx_pkg::STRIP_NORMAL;
            tok_reg    <= TOK_CLEAN;
            line_reg   <= LINE_BITS'(1);
            halted_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            if (char_in.valid && char_in.ready)
            begin
                in_v_reg <= 1'b1;
            end
            else if (process)
            begin
                in_v_reg <= 1'b0;
            end
            if (process)
            begin
                strip_reg  <= strip_next;
                tok_reg    <= tok_next;
                line_reg   <= line_next;
                halted_reg <= halted_next;
            end
            if (process && (n_new != 3'd0))
            begin
                cnt_reg <= n_new;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            ch_reg  <= char_in.ch;
            eot_reg <= char_in.end_of_text;
        end
        if (process && (n_new != 3'd0))
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= new_res[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (process && (n_new != 3'd0)) |-> buf_free)
        else $error("result buffer overwritten");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (n_new == 3'd0))
        else $error("token produced after halt");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_run_ends_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cnt_reg == 3'd1)) |-> token_out.last_of_run)
        else $error("last token of a run not marked");

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (process && !halted_reg && eot && cand_v[1] && (cand[1].kind == clx_pkg::KIND_EOF))
        |=> ((line_reg == LINE_BITS'(1)) && (strip_reg == clx_pkg::STRIP_NORMAL)))
        else $error("state not restarted after end of file");

endmodule

// ----- tb/sv/tb_comment_stripping_lexer.sv -----
// tb_comment_stripping_lexer: self-checking bench for the comment-stripping lexer,
// directed and random source text against a token predictor held in a scoreboard class.
// Depends on clx_pkg, the channel interfaces in clx_if.sv and comment_stripping_lexer.

module tb_comment_stripping_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20_000;

    class lexer_scoreboard;
        clx_pkg::strip_mode_t strip;
        clx_pkg::lex_mode_t   lex;
        logic [63:0]          tok_text;
        logic [7:0]           tok_len;
        logic [30:0]          num_acc;
        int unsigned          line_no;
        bit                   stopped;
        clx_pkg::out_item_t   step_tokens[$];
        clx_pkg::out_item_t   tokens_due[$];
        int                   errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void clear_token();
            tok_text = '0;
            tok_len  = '0;
            num_acc  = '0;
            lex      = clx_pkg::LEX_START;
        endfunction

        function void restart();
            strip   = clx_pkg::STRIP_NORMAL;
            line_no = 1;
            stopped = 1'b0;
            clear_token();
        endfunction

        function void emit(clx_pkg::kind_t k, logic [7:0] len, logic [63:0] text,
                           logic [30:0] num);
            clx_pkg::out_item_t t;
            if (step_tokens.size() >= 4)
                return;
            t.kind        = k;
            t.line        = line_no[15:0];
            t.length      = len;
            t.text_head   = text;
            t.num_value   = num;
            t.last_of_run = 1'b0;
            step_tokens.insert(step_tokens.size(), t);
        endfunction

        function void add_char(logic [7:0] c);
            if (tok_len < 8)
                tok_text[int'(tok_len) * 8 +: 8] = c;
            if (tok_len < 255)
                tok_len++;
        endfunction

        function clx_pkg::kind_t word_kind();
            string words[6];
            bit same;
            words = '{"else", "if", "int", "return", "void", "while"};
            for (int k = 0; k < 6; k++)
            begin
                same = (tok_len == words[k].len());
                for (int i = 0; same && i < words[k].len(); i++)
                    if (tok_text[i * 8 +: 8] != words[k][i])
                        same = 1'b0;
                if (same)
                    return clx_pkg::kind_t'(int'(clx_pkg::KIND_ELSE) + k);
            end
            return clx_pkg::KIND_ID;
        endfunction

        function bit single_symbol(logic [7:0] c, output clx_pkg::kind_t k);
            bit found;
            found = 1'b1;
            case (c)
                "+": k = clx_pkg::KIND_PLUS;
                "-": k = clx_pkg::KIND_MINUS;
                "*": k = clx_pkg::KIND_STAR;
                "/": k = clx_pkg::KIND_SLASH;
                "<": k = clx_pkg::KIND_LT;
                ">": k = clx_pkg::KIND_GT;
                "=": k = clx_pkg::KIND_ASSIGN;
                ";": k = clx_pkg::KIND_SEMI;
                ",": k = clx_pkg::KIND_COMMA;
                "(": k = clx_pkg::KIND_LPAREN;
                ")": k = clx_pkg::KIND_RPAREN;
                "[": k = clx_pkg::KIND_LBRACK;
                "]": k = clx_pkg::KIND_RBRACK;
                "{": k = clx_pkg::KIND_LBRACE;
                "}": k = clx_pkg::KIND_RBRACE;
                default:
                begin
                    k = clx_pkg::KIND_BAD;
                    found = 1'b0;
                end
            endcase
            return found;
        endfunction

        function void halt_bad(logic [7:0] c);
            emit(clx_pkg::KIND_BAD, 8'd1, {56'd0, c}, '0);
            stopped = 1'b1;
        endfunction

        function bit flush();
            clx_pkg::kind_t k;
            bit ok;
            ok = 1'b1;
            case (lex)
                clx_pkg::LEX_NUM: emit(clx_pkg::KIND_NUM, tok_len, tok_text, num_acc);
                clx_pkg::LEX_ID:  emit(word_kind(), tok_len, tok_text, '0);
                clx_pkg::LEX_REL:
                begin
                    if (single_symbol(tok_text[7:0], k))
                        emit(k, tok_len, tok_text, '0);
                    else
                    begin
                        halt_bad(tok_text[7:0]);
                        ok = 1'b0;
                    end
                end
                default: ;
            endcase
            clear_token();
            return ok;
        endfunction

        function void lex_char(logic [7:0] c);
            clx_pkg::kind_t k;
            logic [7:0] f;
            longint v;
            if (stopped)
                return;
            case (lex)
                clx_pkg::LEX_NUM:
                begin
                    if (c inside {["0":"9"]})
                    begin
                        add_char(c);
                        v = longint'(num_acc) * 10 + (c - clx_pkg::CH_DIGIT0);
                        num_acc = (v > clx_pkg::NUM_MAX) ? clx_pkg::NUM_MAX : v[30:0];
                        return;
                    end
                    void'(flush());
                end
                clx_pkg::LEX_ID:
                begin
                    if (c inside {["a":"z"], ["A":"Z"]})
                    begin
                        add_char(c);
                        return;
                    end
                    void'(flush());
                end
                clx_pkg::LEX_REL:
                begin
                    if (c == clx_pkg::CH_EQ)
                    begin
                        f = tok_text[7:0];
                        add_char(c);
                        emit(f == clx_pkg::CH_LT ? clx_pkg::KIND_LE :
                             f == clx_pkg::CH_GT ? clx_pkg::KIND_GE :
                             f == clx_pkg::CH_EQ ? clx_pkg::KIND_EQ : clx_pkg::KIND_NE,
                             tok_len, tok_text, '0);
                        clear_token();
                        return;
                    end
                    if (!flush())
                        return;
                end
                default: ;
            endcase
            if (c == clx_pkg::CH_SPACE || c == clx_pkg::CH_TAB || c == clx_pkg::CH_NL)
            begin
                if (c == clx_pkg::CH_NL && line_no < 16'hFFFF)
                    line_no++;
            end
            else if (c inside {["0":"9"]})
            begin
                add_char(c);
                num_acc = c - clx_pkg::CH_DIGIT0;
                lex = clx_pkg::LEX_NUM;
            end
            else if (c inside {["a":"z"], ["A":"Z"]})
            begin
                add_char(c);
                lex = clx_pkg::LEX_ID;
            end
            else if (c inside {"<", ">", "!", "="})
            begin
                add_char(c);
                lex = clx_pkg::LEX_REL;
            end
            else if (single_symbol(c, k))
                emit(k, 8'd1, {56'd0, c}, '0);
            else
                halt_bad(c);
        endfunction

        function void end_of_source();
            if (strip == clx_pkg::STRIP_COMMENT || strip == clx_pkg::STRIP_STAR)
            begin
                emit(clx_pkg::KIND_OPEN, '0, '0, '0);
                stopped = 1'b1;
                return;
            end
            if (!flush())
                return;
            emit(clx_pkg::KIND_EOF, '0, '0, '0);
            restart();
        endfunction

        function void take_char(logic [7:0] c, logic eot);
            step_tokens.delete();
            if (stopped)
                return;
            if (eot || c == clx_pkg::CH_NUL)
                end_of_source();
            else
            begin
                case (strip)
                    clx_pkg::STRIP_NORMAL:
                        if (c == clx_pkg::CH_SLASH)
                            strip = clx_pkg::STRIP_SLASH;
                        else
                            lex_char(c);
                    clx_pkg::STRIP_SLASH:
                        if (c == clx_pkg::CH_STAR)
                            strip = clx_pkg::STRIP_COMMENT;
                        else
                        begin
                            strip = clx_pkg::STRIP_NORMAL;
                            lex_char(clx_pkg::CH_SLASH);
                            lex_char(c);
                        end
                    clx_pkg::STRIP_COMMENT:
                        if (c == clx_pkg::CH_STAR)
                            strip = clx_pkg::STRIP_STAR;
                    default:
                        if (c == clx_pkg::CH_SLASH)
                            strip = clx_pkg::STRIP_NORMAL;
                        else if (c != clx_pkg::CH_STAR)
                            strip = clx_pkg::STRIP_COMMENT;
                endcase
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            foreach (step_tokens[i])
                tokens_due.insert(tokens_due.size(), step_tokens[i]);
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_token(clx_pkg::out_item_t got);
            clx_pkg::out_item_t want;
            if (tokens_due.size() == 0)
            begin
                report($sformatf("unexpected token kind %0d line %0d", got.kind, got.line));
                return;
            end
            want = tokens_due.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("line", got.line, want.line);
            compare_field("length", got.length, want.length);
            compare_field("text_head", got.text_head, want.text_head);
            compare_field("num_value", got.num_value, want.num_value);
            compare_field("last_of_run", got.last_of_run, want.last_of_run);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    int   chars_sent = 0;

    string keywords[6] = '{"else", "if", "int", "return", "void", "while"};

    lexer_scoreboard    book;
    clx_pkg::out_item_t seen_token;

    clx_in_if  in_ch ();
    clx_out_if tok ();

    comment_stripping_lexer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (in_ch),
        .token_out (tok)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_comment_stripping_lexer: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                book.take_char(in_ch.ch, in_ch.end_of_text);
            if (tok.valid === 1'b1 && tok.ready === 1'b1)
            begin
                seen_token.kind        = tok.kind;
                seen_token.line        = tok.line;
                seen_token.length      = tok.length;
                seen_token.text_head   = tok.text_head;
                seen_token.num_value   = tok.num_value;
                seen_token.last_of_run = tok.last_of_run;
                book.check_token(seen_token);
            end
        end
    end

    // token sink with random stalls
    initial
    begin
        int stall;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                tok.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok.ready <= 1'b1;
            @(posedge clk);
            while (tok.valid !== 1'b1)
                @(posedge clk);
        end
    end

    task automatic push_char(input logic [7:0] c, input logic eot);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.ch          <= c;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b0);
    endtask

    task automatic push_end();
        if ($urandom_range(0, 1))
            push_char(8'($urandom_range(0, 255)), 1'b1);
        else
            push_char(clx_pkg::CH_NUL, 1'b0);
    endtask

    // comment body of random bytes that never closes early
    task automatic push_comment(input int body);
        logic [7:0] b;
        logic [7:0] prev;
        prev = clx_pkg::CH_SPACE;
        push_text("/*");
        for (int i = 0; i < body; i++)
        begin
            b = 8'($urandom_range(1, 255));
            if (prev == clx_pkg::CH_STAR && b == clx_pkg::CH_SLASH)
                b = "x";
            push_char(b, 1'b0);
            prev = b;
        end
    endtask

    task automatic random_piece();
        string syms;
        string rels[4];
        string follow;
        int n;
        syms   = "+-*;,()[]{}<>=";
        rels   = '{"<=", ">=", "==", "!="};
        follow = "ab7 ;+(<=\n";
        case ($urandom_range(0, 11))
            0, 1: push_text(keywords[$urandom_range(0, 5)]);
            2, 3:
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    push_char(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                      : $urandom_range("A", "Z")), 1'b0);
            end
            4, 5:
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    push_char(8'($urandom_range("0", "9")), 1'b0);
            end
            6: push_char(syms[$urandom_range(0, syms.len() - 1)], 1'b0);
            7: push_text(rels[$urandom_range(0, 3)]);
            8, 9: push_char($urandom_range(0, 2) == 0 ? clx_pkg::CH_TAB :
                            $urandom_range(0, 1) ? clx_pkg::CH_NL : clx_pkg::CH_SPACE, 1'b0);
            10:
            begin
                push_comment($urandom_range(0, 6));
                repeat ($urandom_range(1, 3))
                    push_char(clx_pkg::CH_STAR, 1'b0);
                push_char(clx_pkg::CH_SLASH, 1'b0);
            end
            default:
            begin
                push_char(clx_pkg::CH_SLASH, 1'b0);
                push_char(follow[$urandom_range(0, follow.len() - 1)], 1'b0);
            end
        endcase
        if ($urandom_range(0, 24) == 0)
            push_end();
    endtask

    initial
    begin
        string odd;
        int start;
        odd  = "#@?~$%";
        book = new();
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.ch          <= '0;
        in_ch.end_of_text <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keywords, near-keywords, number limits
        push_text("else if int return void while elsewhere If9 els\t");
        push_text("0 2147483647 2147483648\n");
        push_char(8'($urandom_range(0, 255)), 1'b1);
        // every symbol, relational pairs, lone slashes, zero byte as end
        push_text("+-*<=>===!=<>=;,()[]{}a/b/=c x=/+ 12/-");
        push_char(clx_pkg::CH_NUL, 1'b0);
        // comments vanish, star runs, trailing slash dropped
        push_text("x/*a\n**/y/***/z/*/ ");
        push_char(8'hFF, 1'b0);
        push_text("*/\n5/");
        push_char(8'($urandom_range(0, 255)), 1'b1);

        start = chars_sent;
        while (chars_sent - start < 12)
            random_piece();

        // one halting case, then items that must be ignored
        push_text("q1");
        case ($urandom_range(0, 3))
            0:
                if ($urandom_range(0, 1))
                    push_char(8'($urandom_range(128, 255)), 1'b0);
                else
                    push_char(odd[$urandom_range(0, odd.len() - 1)], 1'b0);
            1: push_text($urandom_range(0, 1) ? "!;" : "!a");
            2:
            begin
                push_text("!");
                push_end();
            end
            default:
            begin
                push_comment($urandom_range(0, 4));
                push_end();
            end
        endcase
        repeat (6)
            push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_ch.valid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (book.errors == 0)
            $display("tb_comment_stripping_lexer: done, clean");
        else
            $display("tb_comment_stripping_lexer: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/clx_pkg.sv
design/clx_if.sv
design/comment_stripping_lexer.sv
tb/sv/tb_comment_stripping_lexer.sv
